// ===== hw/rtl/sbsh_pkg.sv =====
// sbsh_pkg: shared types, constants and hash step functions for the
// selectable byte stream hash; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbsh_pkg;

    localparam int unsigned MAX_BUCKET_BITS = 24;

    localparam int unsigned HASH_W   = 32;
    localparam int unsigned SUM_W    = 16;
    localparam int unsigned INDEX_W  = 24;
    localparam int unsigned BITS_W   = 5;
    localparam int unsigned ALG_W    = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 5;

    localparam logic [HASH_W-1:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [SUM_W:0]    ADLER_MOD = 17'd65521;
    localparam logic [HASH_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;

    localparam logic [BITS_W-1:0] BUCKET_BITS_RESET = 5'd10;
    localparam logic [BITS_W:0]   BUCKET_BITS_MAX   = (BITS_W+1)'(MAX_BUCKET_BITS);

    typedef enum logic [ALG_W-1:0] {
        ALG_OAAT     = 2'd0,
        ALG_CRC32    = 2'd1,
        ALG_ADLER32  = 2'd2,
        ALG_OAAT_ALT = 2'd3
    } alg_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALGORITHM_SELECT = 1'b0,
        CFG_BUCKET_BITS      = 1'b1
    } cfg_idx_t;

    // one entry of the reflected crc-32 byte table
    function automatic logic [HASH_W-1:0] crc_table_entry(input logic [7:0] idx);
        logic [HASH_W-1:0] c;
        c = {24'd0, idx};
        for (int j = 0; j < 8; j++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [HASH_W-1:0] oaat_absorb(input logic [HASH_W-1:0] h_in,
                                                      input logic [7:0] b);
        logic [HASH_W-1:0] h;
        h = h_in + {24'd0, b};
        h = h + (h << 10);
        h = h ^ (h >> 6);
        return h;
    endfunction

    function automatic logic [HASH_W-1:0] oaat_finish(input logic [HASH_W-1:0] h_in);
        logic [HASH_W-1:0] h;
        h = h_in + (h_in << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h;
    endfunction

    function automatic logic [HASH_W-1:0] bucket_mask(input logic [BITS_W-1:0] bits_in);
        logic [BITS_W:0] bits;
        bits = ({1'b0, bits_in} > BUCKET_BITS_MAX) ? BUCKET_BITS_MAX : {1'b0, bits_in};
        if (bits >= (BITS_W+1)'(HASH_W)) begin
            return ALL_ONES;
        end
        return (32'd1 << bits) - 32'd1;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/selectable_byte_stream_hash.sv =====
// selectable_byte_stream_hash: byte-serial key hash, one-at-a-time, crc-32 or adler-32
// depends on sbsh_pkg
//
//   channel   direction   handshake            payload
//   in        input       in_valid / in_stall  key_byte, first_byte, last_byte
//   out       output      out_valid / out_stall hash_value, bucket_index
//   cfg       input       cfg_we               cfg_index, cfg_data
//
// one byte per clock while in_stall is low; after its last byte is taken a result
// passes the input register, then the finish register, then the result register
// the running state is updated in the absorb stage, so each byte sees the previous one
// reset clears the state to start values and selects one-at-a-time, bucket_bits 10
// out_stall holds the result register; the finish register can still take one result
// and non-last bytes keep being absorbed, and in_stall rises only when a last byte has no free slot ahead of it
`timescale 1ns / 1ps
`default_nettype none

module selectable_byte_stream_hash (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [sbsh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sbsh_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [7:0]                          key_byte,
    input  wire logic                                first_byte,
    input  wire logic                                last_byte,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [sbsh_pkg::HASH_W-1:0]              hash_value,
    output logic [sbsh_pkg::INDEX_W-1:0]             bucket_index
);
    import sbsh_pkg::*;

    // configuration
    alg_t              alg_reg,  alg_next;
    logic [BITS_W-1:0] bbits_reg, bbits_next;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              in_first_reg;
    logic              in_last_reg;

    // running state
    logic [HASH_W-1:0] running_hash_reg, running_hash_next;
    logic [SUM_W-1:0]  sum_low_reg, sum_low_next;
    logic [SUM_W-1:0]  sum_high_reg, sum_high_next;

    // finish stage register
    logic              mid_valid_reg, mid_valid_next;
    logic [HASH_W-1:0] mid_hash_reg;
    alg_t              mid_alg_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [HASH_W-1:0] out_hash_reg;
    logic [INDEX_W-1:0] out_index_reg;

    logic              accept;
    logic              proc;
    logic              proc_last;
    logic              mid_move;
    logic              mid_free;

    logic [HASH_W-1:0] cur_hash;
    logic [SUM_W-1:0]  cur_low;
    logic [SUM_W-1:0]  cur_high;
    logic [HASH_W-1:0] crc_h;
    logic [HASH_W-1:0] new_hash;
    logic [SUM_W:0]    adler_a;
    logic [SUM_W:0]    adler_s;
    logic [SUM_W-1:0]  new_low;
    logic [SUM_W-1:0]  new_high;
    logic [HASH_W-1:0] absorbed;
    logic [HASH_W-1:0] fin_hash;

    // handshake
    assign mid_move  = !out_valid_reg || !out_stall;
    assign mid_free  = !mid_valid_reg || mid_move;
    assign proc      = in_valid_reg && (!in_last_reg || mid_free);
    assign proc_last = proc && in_last_reg;
    assign in_stall  = in_valid_reg && !proc;
    assign accept    = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign hash_value   = out_hash_reg;
    assign bucket_index = out_index_reg;

    // absorb stage
    always_comb
    begin
        cur_hash = in_first_reg ? '0 : running_hash_reg;
        cur_low  = in_first_reg ? SUM_W'(1) : sum_low_reg;
        cur_high = in_first_reg ? '0 : sum_high_reg;

        crc_h = ~cur_hash;
        crc_h = (crc_h >> 8) ^ crc_table_entry(crc_h[7:0] ^ in_byte_reg);

        adler_a = {1'b0, cur_low} + {9'd0, in_byte_reg};
        if (adler_a >= ADLER_MOD)
        begin
            adler_a = adler_a - ADLER_MOD;
        end
        adler_s = {1'b0, cur_high} + adler_a;
        if (adler_s >= ADLER_MOD)
        begin
            adler_s = adler_s - ADLER_MOD;
        end

        new_hash = cur_hash;
        new_low  = cur_low;
        new_high = cur_high;
        unique case (alg_reg)
            ALG_CRC32:
            begin
                new_hash = ~crc_h;
            end
            ALG_ADLER32:
            begin
                new_low  = adler_a[SUM_W-1:0];
                new_high = adler_s[SUM_W-1:0];
            end
            ALG_OAAT, ALG_OAAT_ALT:
            begin
                new_hash = oaat_absorb(cur_hash, in_byte_reg);
            end
        endcase

        absorbed = (alg_reg == ALG_ADLER32) ? {new_high, new_low} : new_hash;
    end

    // finish stage
    always_comb
    begin
        fin_hash = mid_hash_reg;
        if (mid_alg_reg == ALG_OAAT || mid_alg_reg == ALG_OAAT_ALT)
        begin
            fin_hash = oaat_finish(mid_hash_reg);
        end
    end

    // next state
    always_comb
    begin
        alg_next   = alg_reg;
        bbits_next = bbits_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALGORITHM_SELECT: alg_next   = alg_t'(cfg_data[ALG_W-1:0]);
                CFG_BUCKET_BITS:      bbits_next = cfg_data[BITS_W-1:0];
            endcase
        end

        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end

        running_hash_next = running_hash_reg;
        sum_low_next      = sum_low_reg;
        sum_high_next     = sum_high_reg;
        if (proc_last)
        begin
            running_hash_next = '0;
            sum_low_next      = SUM_W'(1);
            sum_high_next     = '0;
        end
        else if (proc)
        begin
            running_hash_next = new_hash;
            sum_low_next      = new_low;
            sum_high_next     = new_high;
        end

        mid_valid_next = mid_valid_reg;
        if (proc_last)
        begin
            mid_valid_next = 1'b1;
        end
        else if (mid_move)
        begin
            mid_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (mid_valid_reg && mid_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alg_reg          <= ALG_OAAT;
            bbits_reg        <= BUCKET_BITS_RESET;
            in_valid_reg     <= 1'b0;
            running_hash_reg <= '0;
            sum_low_reg      <= SUM_W'(1);
            sum_high_reg     <= '0;
            mid_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            alg_reg          <= alg_next;
            bbits_reg        <= bbits_next;
            in_valid_reg     <= in_valid_next;
            running_hash_reg <= running_hash_next;
            sum_low_reg      <= sum_low_next;
            sum_high_reg     <= sum_high_next;
            mid_valid_reg    <= mid_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= key_byte;
            in_first_reg <= first_byte;
            in_last_reg  <= last_byte;
        end
        if (proc_last)
        begin
            mid_hash_reg <= absorbed;
            mid_alg_reg  <= alg_reg;
        end
        if (mid_valid_reg && mid_move)
        begin
            out_hash_reg  <= fin_hash;
            out_index_reg <= INDEX_W'(fin_hash & bucket_mask(bbits_reg));
        end
    end

`ifndef NO_ASSERTIONS
    a_adler_low_range: assert property (@(posedge clk) disable iff (!rst_n)
        sum_low_reg < ADLER_MOD[SUM_W-1:0])
        else $error("adler low sum out of range");

    a_adler_high_range: assert property (@(posedge clk) disable iff (!rst_n)
        sum_high_reg < ADLER_MOD[SUM_W-1:0])
        else $error("adler high sum out of range");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        proc_last |=> mid_valid_reg && running_hash_reg == '0
                      && sum_low_reg == SUM_W'(1) && sum_high_reg == '0)
        else $error("last byte did not queue a result and restart the state");

    a_mid_held: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg && !mid_move |=> mid_valid_reg && $stable(mid_hash_reg))
        else $error("pending result lost while output stalled");

    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && in_last_reg && mid_valid_reg && out_valid_reg)
        else $error("input stalled without a blocked last byte");
`endif

endmodule

`default_nettype wire
